// ===== src/xesd_pkg.sv =====
// Package with the shared constants, types and helper functions of the entity decoder.
package xesd_pkg;

   localparam int ENTITY_MAX = 10;
   localparam int LEN_W      = $clog2(ENTITY_MAX + 1);
   localparam int CNT_W      = $clog2(ENTITY_MAX + 2);
   localparam int ADDR_W     = $clog2(ENTITY_MAX);
   localparam int SAT_MAG    = 256;
   localparam int MAG_W      = $clog2(SAT_MAG + 1);
   localparam int CODE_LIMIT = 'h80;

   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;

   typedef logic [ENTITY_MAX-1:0][7:0] chars_type;

   typedef enum logic [3:0] {
      ST_IDLE    = 4'b0001,
      ST_FLUSH   = 4'b0010,
      ST_PARSE   = 4'b0100,
      ST_NUM_OUT = 4'b1000
   } state_type;

   // Commands from the sequencer to the digit accumulator.
   typedef struct packed {
      logic clear;
      logic step;
      logic hex;
   } num_ctrl_type;

   // Status of the digit accumulator.
   typedef struct packed {
      logic       is_digit;
      logic       code_ok;
      logic [6:0] code;
   } num_stat_type;

   // Result of the named-entity compare.
   typedef struct packed {
      logic       hit;
      logic [7:0] code;
   } match_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_x(input logic [7:0] c);
      return (c == CH_LX) || (c == CH_UX);
   endfunction

endpackage

// ===== src/xesd_if.sv =====
// Valid/ready channel interfaces for the request and response streams.
interface xesd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       start_of_run;

   modport source (output valid, output in_byte, output start_of_run, input ready);
   modport sink   (input valid, input in_byte, input start_of_run, output ready);
endinterface

interface xesd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== src/xesd_num_unit.sv =====
// Shared digit accumulator: one decimal or hex digit is folded in per step, with saturation.
module xesd_num_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  xesd_pkg::num_ctrl_type ctrl,
   input  logic [7:0]            ch,
   output xesd_pkg::num_stat_type stat
);
   import xesd_pkg::*;

   logic [MAG_W-1:0]   mag_ff;
   logic [MAG_W-1:0]   mag_in;
   logic [3:0]         dval;
   logic               dok;
   logic [MAG_W+4:0]   acc;

   always_comb begin
      dval = 4'd0;
      dok  = 1'b0;
      if ((ch >= 8'h30) && (ch <= 8'h39)) begin
         dval = 4'(ch - 8'h30);
         dok  = 1'b1;
      end else if ((ch >= 8'h61) && (ch <= 8'h66)) begin
         dval = 4'(ch - 8'h61 + 8'd10);
         dok  = ctrl.hex;
      end else if ((ch >= 8'h41) && (ch <= 8'h46)) begin
         dval = 4'(ch - 8'h41 + 8'd10);
         dok  = ctrl.hex;
      end
   end

   // Multiply by the base is a shift for hex and shift-and-add for decimal.
   always_comb begin
      if (ctrl.hex) begin
         acc = ((MAG_W+5)'(mag_ff) << 4) + (MAG_W+5)'(dval);
      end else begin
         acc = ((MAG_W+5)'(mag_ff) << 3) + ((MAG_W+5)'(mag_ff) << 1) + (MAG_W+5)'(dval);
      end
   end

   always_comb begin
      mag_in = mag_ff;
      if (ctrl.clear) begin
         mag_in = '0;
      end else if (ctrl.step && dok) begin
         if (acc > (MAG_W+5)'(SAT_MAG)) begin
            mag_in = MAG_W'(SAT_MAG);
         end else begin
            mag_in = acc[MAG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_ff <= '0;
      end else begin
         mag_ff <= mag_in;
      end
   end

   assign stat.is_digit = dok;
   assign stat.code_ok  = (mag_ff != '0) && (mag_ff < MAG_W'(CODE_LIMIT));
   assign stat.code     = mag_ff[6:0];

endmodule

// ===== src/xesd_name_match.sv =====
// Compares the collected entity bytes against the five predefined entity names.
module xesd_name_match (
   input  xesd_pkg::chars_type        chars,
   input  logic [xesd_pkg::LEN_W-1:0] len,
   output xesd_pkg::match_type        match
);
   import xesd_pkg::*;

   logic is_lt, is_gt, is_amp, is_quot, is_apos;

   assign is_lt   = (len == LEN_W'(2)) && (chars[0] == 8'h6C) && (chars[1] == 8'h74);
   assign is_gt   = (len == LEN_W'(2)) && (chars[0] == 8'h67) && (chars[1] == 8'h74);
   assign is_amp  = (len == LEN_W'(3)) && (chars[0] == 8'h61) && (chars[1] == 8'h6D)
                    && (chars[2] == 8'h70);
   assign is_quot = (len == LEN_W'(4)) && (chars[0] == 8'h71) && (chars[1] == 8'h75)
                    && (chars[2] == 8'h6F) && (chars[3] == 8'h74);
   assign is_apos = (len == LEN_W'(4)) && (chars[0] == 8'h61) && (chars[1] == 8'h70)
                    && (chars[2] == 8'h6F) && (chars[3] == 8'h73);

   always_comb begin
      match.hit  = is_lt | is_gt | is_amp | is_quot | is_apos;
      match.code = CH_APOS;
      if (is_lt) begin
         match.code = CH_LT;
      end else if (is_gt) begin
         match.code = CH_GT;
      end else if (is_amp) begin
         match.code = CH_AMP;
      end else if (is_quot) begin
         match.code = CH_QUOT;
      end
   end

endmodule

// ===== src/xml_entity_stream_decoder_top.sv =====
// Top level of the streaming XML character-entity decoder: sequencer, entity buffer and output register.
// Bytes outside an entity and entities that close with a predefined name go to the output register
// as the input byte is taken; a byte collected into an entity is only stored. A numeric reference
// is parsed after its ';' by the single digit accumulator, walking the collected bytes one at a time.
// A runaway or unknown entity is flushed from the entity buffer ('&', collected bytes, trailing byte)
// one byte per cycle while the output can take one. The input is not ready while a numeric parse
// or a flush runs, nor while the output register holds a byte that the sink has not taken.
module xml_entity_stream_decoder_top (
   input logic        clock,
   input logic        reset,
   xesd_req_if.sink   req_chan,
   xesd_rsp_if.source rsp_chan
);
   import xesd_pkg::*;

   state_type        state_ff, state_in;
   logic             pend_ff, pend_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       trail_ff, trail_in;
   logic             hex_ff, hex_in;
   logic             sign_done_ff, sign_done_in;
   logic             any_digit_ff, any_digit_in;
   logic             zero_lead_ff, zero_lead_in;
   logic             neg_ff, neg_in;
   chars_type        chars_ff;

   logic             rsp_valid_ff;
   logic [7:0]       rsp_byte_ff;
   logic             rsp_last_ff;

   logic             load_ok, load, load_last, accept, wr_en;
   logic [7:0]       load_byte, c, rd_byte;
   logic [CNT_W-1:0] rd_idx;
   logic             eff_pend;
   logic [LEN_W-1:0] eff_len;
   num_ctrl_type     nctrl;
   num_stat_type     nstat;
   match_type        match;

   xesd_name_match u_match (
      .chars (chars_ff),
      .len   (len_ff),
      .match (match)
   );

   xesd_num_unit u_num (
      .clock (clock),
      .reset (reset),
      .ctrl  (nctrl),
      .ch    (rd_byte),
      .stat  (nstat)
   );

   assign load_ok        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && load_ok;
   assign accept         = req_chan.valid && req_chan.ready;
   assign c              = req_chan.in_byte;
   assign eff_pend       = pend_ff && !req_chan.start_of_run;
   assign eff_len        = req_chan.start_of_run ? '0 : len_ff;

   // The flush walks the buffer one behind its counter, since position zero sends the ampersand.
   assign rd_idx  = (state_ff == ST_FLUSH) ? (cnt_ff - CNT_W'(1)) : cnt_ff;
   assign rd_byte = chars_ff[rd_idx[ADDR_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      trail_in     = trail_ff;
      hex_in       = hex_ff;
      sign_done_in = sign_done_ff;
      any_digit_in = any_digit_ff;
      zero_lead_in = zero_lead_ff;
      neg_in       = neg_ff;
      load         = 1'b0;
      load_byte    = c;
      load_last    = 1'b0;
      wr_en        = 1'b0;
      nctrl.clear  = 1'b0;
      nctrl.step   = 1'b0;
      nctrl.hex    = hex_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.start_of_run) begin
                  pend_in = 1'b0;
                  len_in  = '0;
               end
               if (eff_pend) begin
                  if (c == CH_SEMI) begin
                     pend_in = 1'b0;
                     if (match.hit) begin
                        load      = 1'b1;
                        load_byte = match.code;
                        load_last = 1'b1;
                     end else if ((eff_len > LEN_W'(1)) && (chars_ff[0] == CH_HASH)) begin
                        state_in     = ST_PARSE;
                        hex_in       = is_x(chars_ff[1]);
                        cnt_in       = is_x(chars_ff[1]) ? CNT_W'(2) : CNT_W'(1);
                        sign_done_in = 1'b0;
                        any_digit_in = 1'b0;
                        zero_lead_in = 1'b0;
                        neg_in       = 1'b0;
                        nctrl.clear  = 1'b1;
                     end else begin
                        state_in = ST_FLUSH;
                        cnt_in   = '0;
                        trail_in = CH_SEMI;
                     end
                  end else if (eff_len < LEN_W'(ENTITY_MAX)) begin
                     wr_en  = 1'b1;
                     len_in = eff_len + LEN_W'(1);
                  end else begin
                     pend_in  = 1'b0;
                     state_in = ST_FLUSH;
                     cnt_in   = '0;
                     trail_in = c;
                  end
               end else if (c == CH_AMP) begin
                  pend_in = 1'b1;
                  len_in  = '0;
               end else begin
                  load      = 1'b1;
                  load_last = 1'b1;
               end
            end
         end
         ST_FLUSH: begin
            if (load_ok) begin
               load   = 1'b1;
               cnt_in = cnt_ff + CNT_W'(1);
               if (cnt_ff == '0) begin
                  load_byte = CH_AMP;
               end else if (cnt_ff <= CNT_W'(len_ff)) begin
                  load_byte = rd_byte;
               end else begin
                  load_byte = trail_ff;
                  load_last = 1'b1;
                  state_in  = ST_IDLE;
                  len_in    = '0;
               end
            end
         end
         ST_PARSE: begin
            if (cnt_ff >= CNT_W'(len_ff)) begin
               state_in = ST_NUM_OUT;
            end else if (!sign_done_ff) begin
               if (is_space(rd_byte)) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else if (rd_byte == CH_PLUS) begin
                  sign_done_in = 1'b1;
                  cnt_in       = cnt_ff + CNT_W'(1);
               end else if (rd_byte == CH_MINUS) begin
                  neg_in   = 1'b1;
                  state_in = ST_NUM_OUT;
               end else begin
                  sign_done_in = 1'b1;
               end
            end else if (hex_ff && zero_lead_ff && is_x(rd_byte)) begin
               // A lone leading zero followed by x is the 0x prefix; the zero added nothing.
               zero_lead_in = 1'b0;
               cnt_in       = cnt_ff + CNT_W'(1);
            end else if (nstat.is_digit) begin
               nctrl.step   = 1'b1;
               any_digit_in = 1'b1;
               zero_lead_in = !any_digit_ff && (rd_byte == CH_ZERO);
               cnt_in       = cnt_ff + CNT_W'(1);
            end else begin
               state_in = ST_NUM_OUT;
            end
         end
         ST_NUM_OUT: begin
            if (load_ok) begin
               load      = 1'b1;
               load_last = 1'b1;
               load_byte = (neg_ff || !nstat.code_ok) ? CH_QMARK : {1'b0, nstat.code};
               state_in  = ST_IDLE;
               len_in    = '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         len_ff       <= '0;
         cnt_ff       <= '0;
         hex_ff       <= 1'b0;
         sign_done_ff <= 1'b0;
         any_digit_ff <= 1'b0;
         zero_lead_ff <= 1'b0;
         neg_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         hex_ff       <= hex_in;
         sign_done_ff <= sign_done_in;
         any_digit_ff <= any_digit_in;
         zero_lead_ff <= zero_lead_in;
         neg_ff       <= neg_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      trail_ff <= trail_in;
      if (load) begin
         rsp_byte_ff <= load_byte;
         rsp_last_ff <= load_last;
      end
      if (wr_en) begin
         chars_ff[eff_len[ADDR_W-1:0]] <= c;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_byte    = rsp_byte_ff;
   assign rsp_chan.last_of_run = rsp_last_ff;

   a_len_bound : assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(ENTITY_MAX))
      else $error("entity length beyond buffer depth");

   a_flush_cnt : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH) |-> (cnt_ff <= CNT_W'(len_ff) + CNT_W'(1)))
      else $error("flush counter ran past the trailing byte");

   a_num_done : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_NUM_OUT) && load_ok) |=>
         ((state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff))
      else $error("numeric result not delivered as the final byte");

   a_busy_blocks : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PARSE) || (state_ff == ST_FLUSH)) |-> !req_chan.ready)
      else $error("input taken while a parse or flush runs");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the streaming XML entity decoder: directed rows, then random text.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xesd_pkg::*;

   typedef enum logic [1:0] {
      ROW_SILENT,
      ROW_ONE,
      ROW_MODEL
   } row_check_type;

   typedef struct packed {
      logic [7:0]    ch;
      logic          start;
      row_check_type how;
      logic [7:0]    want;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } decoded_char_type;

   // Rows marked ROW_ONE carry their single expected byte; ROW_MODEL rows go to the predictor.
   localparam stim_row_type DIRECTED [22] = '{
      '{8'h00, 1'b0, ROW_ONE, 8'h00},
      '{8'hFF, 1'b0, ROW_ONE, 8'hFF},
      '{CH_AMP, 1'b0, ROW_SILENT, 8'h00},
      '{"l", 1'b0, ROW_SILENT, 8'h00},
      '{"t", 1'b0, ROW_SILENT, 8'h00},
      '{CH_SEMI, 1'b0, ROW_ONE, CH_LT},
      '{CH_AMP, 1'b0, ROW_SILENT, 8'h00},
      '{CH_HASH, 1'b0, ROW_SILENT, 8'h00},
      '{CH_MINUS, 1'b0, ROW_SILENT, 8'h00},
      '{"5", 1'b0, ROW_SILENT, 8'h00},
      '{CH_SEMI, 1'b0, ROW_ONE, CH_QMARK},
      '{CH_AMP, 1'b0, ROW_SILENT, 8'h00},
      '{CH_HASH, 1'b0, ROW_SILENT, 8'h00},
      '{CH_LX, 1'b0, ROW_SILENT, 8'h00},
      '{"7", 1'b0, ROW_SILENT, 8'h00},
      '{"F", 1'b0, ROW_SILENT, 8'h00},
      '{CH_SEMI, 1'b0, ROW_MODEL, 8'h00},
      '{CH_AMP, 1'b0, ROW_SILENT, 8'h00},
      '{"A", 1'b1, ROW_ONE, "A"},
      '{CH_AMP, 1'b0, ROW_SILENT, 8'h00},
      '{CH_SEMI, 1'b0, ROW_MODEL, 8'h00},
      '{CH_SEMI, 1'b0, ROW_ONE, CH_SEMI}
   };

   localparam int RANDOM_BYTES = 420;
   localparam int CALM_AFTER   = 340;
   localparam int HOLD_AT      = 100;
   localparam int HOLD_CYCLES  = 300;

   logic clock;
   logic reset;

   xesd_req_if req_chan ();
   xesd_rsp_if rsp_chan ();

   xml_entity_stream_decoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state.
   logic       ent_open;
   logic [7:0] ent_buf [ENTITY_MAX];
   int         ent_len;
   logic [7:0] step_chars [$];

   decoded_char_type expected_chars [$];
   logic [7:0]       seq_ch [$];
   logic             seq_st [$];

   int bytes_in     = 0;
   int bytes_out    = 0;
   int mismatches   = 0;
   int runaway_seqs = 0;
   int numeric_seqs = 0;
   bit calm         = 1'b0;
   bit held_off     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d output bytes still expected.", expected_chars.size());
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic logic blank_char(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic int digit_of(input logic [7:0] c, input int base);
      int v;
      if (c >= "0" && c <= "9") v = c - "0";
      else if (c >= "a" && c <= "f") v = c - "a" + 10;
      else if (c >= "A" && c <= "F") v = c - "A" + 10;
      else return -1;
      return (v < base) ? v : -1;
   endfunction

   function automatic logic entity_is(input string name);
      if (ent_len != name.len()) return 1'b0;
      for (int i = 0; i < ent_len; i++)
         if (ent_buf[i] != name[i]) return 1'b0;
      return 1'b1;
   endfunction

   // Numeric reference value with strtol-like parsing; magnitude saturates above 256.
   function automatic logic [7:0] numeric_code(input int pos, input int base);
      int  mag;
      int  d;
      bit  neg;
      mag = 0;
      neg = 1'b0;
      while (pos < ent_len && blank_char(ent_buf[pos])) pos++;
      if (pos < ent_len && (ent_buf[pos] == CH_PLUS || ent_buf[pos] == CH_MINUS)) begin
         neg = (ent_buf[pos] == CH_MINUS);
         pos++;
      end
      if (base == 16 && pos + 2 < ent_len && ent_buf[pos] == CH_ZERO &&
          (ent_buf[pos+1] == CH_LX || ent_buf[pos+1] == CH_UX) &&
          digit_of(ent_buf[pos+2], 16) >= 0)
         pos += 2;
      while (pos < ent_len) begin
         d = digit_of(ent_buf[pos], base);
         if (d < 0) break;
         mag = mag * base + d;
         if (mag > SAT_MAG) mag = SAT_MAG;
         pos++;
      end
      if (!neg && mag >= 1 && mag < CODE_LIMIT) return mag[7:0];
      return CH_QMARK;
   endfunction

   // Advances the predictor by one input byte and leaves its output bytes in step_chars.
   function automatic void decode_byte(input logic [7:0] c, input logic start);
      step_chars.delete();
      if (start) begin
         ent_open = 1'b0;
         ent_len  = 0;
      end
      if (ent_open) begin
         if (c == CH_SEMI) begin
            if (entity_is("lt")) step_chars.push_back(CH_LT);
            else if (entity_is("gt")) step_chars.push_back(CH_GT);
            else if (entity_is("amp")) step_chars.push_back(CH_AMP);
            else if (entity_is("quot")) step_chars.push_back(CH_QUOT);
            else if (entity_is("apos")) step_chars.push_back(CH_APOS);
            else if (ent_len > 1 && ent_buf[0] == CH_HASH) begin
               if (ent_buf[1] == CH_LX || ent_buf[1] == CH_UX)
                  step_chars.push_back(numeric_code(2, 16));
               else
                  step_chars.push_back(numeric_code(1, 10));
            end else begin
               step_chars.push_back(CH_AMP);
               for (int i = 0; i < ent_len; i++) step_chars.push_back(ent_buf[i]);
               step_chars.push_back(CH_SEMI);
            end
            ent_open = 1'b0;
            ent_len  = 0;
         end else if (ent_len < ENTITY_MAX) begin
            ent_buf[ent_len] = c;
            ent_len++;
         end else begin
            // Runaway entity: everything collected comes back out, then this byte.
            step_chars.push_back(CH_AMP);
            for (int i = 0; i < ent_len; i++) step_chars.push_back(ent_buf[i]);
            step_chars.push_back(c);
            ent_open = 1'b0;
            ent_len  = 0;
         end
      end else if (c == CH_AMP) begin
         ent_open = 1'b1;
         ent_len  = 0;
      end else begin
         step_chars.push_back(c);
      end
   endfunction

   function automatic logic [7:0] body_byte();
      logic [7:0] b;
      do begin
         b = $urandom_range(0, 1) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(0, 255));
      end while (b == CH_SEMI);
      return b;
   endfunction

   function automatic string entity_name(input int k);
      case (k)
         0: return "lt";
         1: return "gt";
         2: return "amp";
         3: return "quot";
         4: return "apos";
         5: return "l";
         6: return "ampx";
         7: return "Lt";
         8: return "quo";
         default: return "#";
      endcase
   endfunction

   function automatic void add_byte(input logic [7:0] b, input logic start);
      seq_ch.push_back(b);
      seq_st.push_back(start);
   endfunction

   // One random piece of text; most pieces are entities closed by ';', with random content.
   function automatic void build_sequence();
      int    kind;
      int    n;
      int    rem;
      bit    hex;
      string nm;
      string hex_digits;
      hex_digits = "0123456789abcdefABCDEF";
      seq_ch.delete();
      seq_st.delete();
      kind = $urandom_range(0, 99);
      if (kind < 22) begin
         n = $urandom_range(1, 6);
         repeat (n) add_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (kind < 42) begin
         nm = entity_name($urandom_range(0, 9));
         add_byte(CH_AMP, 1'b0);
         for (int i = 0; i < nm.len(); i++) add_byte(nm[i], 1'b0);
         add_byte(CH_SEMI, 1'b0);
      end else if (kind < 72) begin
         numeric_seqs++;
         hex = (kind >= 57);
         add_byte(CH_AMP, 1'b0);
         add_byte(CH_HASH, 1'b0);
         if (hex) add_byte($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 2);
            repeat (n) add_byte($urandom_range(0, 1) ? 8'h20 : 8'($urandom_range(9, 13)), 1'b0);
         end
         case ($urandom_range(0, 5))
            0: add_byte(CH_PLUS, 1'b0);
            1: add_byte(CH_MINUS, 1'b0);
            default: ;
         endcase
         if (hex && $urandom_range(0, 3) == 0) begin
            add_byte(CH_ZERO, 1'b0);
            add_byte($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
         end
         // The leading '&' is not collected, so room is ENTITY_MAX less the rest.
         rem = ENTITY_MAX + 1 - seq_ch.size();
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, rem)
                                         : $urandom_range(1, (rem < 3) ? rem : 3);
         repeat (n) begin
            if ($urandom_range(0, 7) == 0) add_byte(body_byte(), 1'b0);
            else if (hex) add_byte(hex_digits[$urandom_range(0, 21)], 1'b0);
            else add_byte(8'($urandom_range("0", "9")), 1'b0);
         end
         add_byte(CH_SEMI, 1'b0);
      end else if (kind < 84) begin
         add_byte(CH_AMP, 1'b0);
         n = $urandom_range(0, ENTITY_MAX);
         repeat (n) add_byte(body_byte(), 1'b0);
         add_byte(CH_SEMI, 1'b0);
      end else if (kind < 93) begin
         runaway_seqs++;
         add_byte(CH_AMP, 1'b0);
         repeat (ENTITY_MAX) add_byte(body_byte(), 1'b0);
         add_byte(($urandom_range(0, 3) == 0) ? CH_AMP : body_byte(), 1'b0);
      end else begin
         // Entity cut short by a start flag.
         add_byte(CH_AMP, 1'b0);
         n = $urandom_range(0, 4);
         repeat (n) add_byte(body_byte(), 1'b0);
         add_byte(8'($urandom_range(0, 255)), 1'b1);
      end
   endfunction

   task automatic maybe_idle();
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic offer_byte(input logic [7:0] ch, input logic start,
                             input row_check_type how, input logic [7:0] want);
      req_chan.valid        <= 1'b1;
      req_chan.in_byte      <= ch;
      req_chan.start_of_run <= start;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      decode_byte(ch, start);
      if (how == ROW_MODEL) begin
         foreach (step_chars[i])
            expected_chars.push_back({step_chars[i], 1'(i == step_chars.size() - 1)});
      end else if (how == ROW_ONE) begin
         expected_chars.push_back({want, 1'b1});
      end
      bytes_in++;
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      decoded_char_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         bytes_out++;
         if (expected_chars.size() == 0) begin
            $error("unexpected output byte %02h (last_of_run %b)",
                   rsp_chan.out_byte, rsp_chan.last_of_run);
            mismatches++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_chan.out_byte !== want.ch) begin
               $error("out_byte: expected %02h, actual %02h", want.ch, rsp_chan.out_byte);
               mismatches++;
            end
            if (rsp_chan.last_of_run !== want.last) begin
               $error("last_of_run: expected %b, actual %b", want.last, rsp_chan.last_of_run);
               mismatches++;
            end
         end
      end
   end

   // Sink side: random stall bursts, one long hold-off so the input backs up, none at the end.
   initial begin
      int stall;
      stall          = 0;
      rsp_chan.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!held_off && bytes_out >= HOLD_AT) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            held_off = 1'b1;
         end else if (stall > 0 && !calm) begin
            rsp_chan.ready <= 1'b0;
            stall--;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall = $urandom_range(1, 18) - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int rand_bytes;
      rand_bytes            = 0;
      ent_open              = 1'b0;
      ent_len               = 0;
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.in_byte      = 8'h00;
      req_chan.start_of_run = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED[i]) begin
         maybe_idle();
         offer_byte(DIRECTED[i].ch, DIRECTED[i].start, DIRECTED[i].how, DIRECTED[i].want);
      end

      while (rand_bytes < RANDOM_BYTES) begin
         build_sequence();
         foreach (seq_ch[i]) begin
            maybe_idle();
            offer_byte(seq_ch[i], seq_st[i] | ($urandom_range(0, 39) == 0), ROW_MODEL, 8'h00);
            rand_bytes++;
            if (rand_bytes >= CALM_AFTER) calm = 1'b1;
         end
      end
      req_chan.valid <= 1'b0;

      while (expected_chars.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      $display("Sent %0d input bytes (%0d numeric references, %0d runaway entities).",
               bytes_in, numeric_seqs, runaway_seqs);
      $display("Checked %0d output bytes with %0d mismatches.", bytes_out, mismatches);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
